@@ hw/rtl/bplc_pkg.sv @@
package bplc_pkg;

   // Widths of the payload and register fields
   localparam int unsigned KindWidth  = 2;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned DebWidth   = 8;
   localparam int unsigned IndexWidth = 3;
   localparam int unsigned DataWidth  = 16;

   // Press kinds reported on the result channel
   localparam logic [KindWidth-1:0] KIND_NONE      = 2'd0;
   localparam logic [KindWidth-1:0] KIND_SHORT     = 2'd1;
   localparam logic [KindWidth-1:0] KIND_LONG      = 2'd2;
   localparam logic [KindWidth-1:0] KIND_VERY_LONG = 2'd3;

   // Register indexes on the configuration channel
   localparam logic [IndexWidth-1:0] REG_ACTIVE_LOW    = 3'd0;
   localparam logic [IndexWidth-1:0] REG_DEBOUNCE      = 3'd1;
   localparam logic [IndexWidth-1:0] REG_WINDOW        = 3'd2;
   localparam logic [IndexWidth-1:0] REG_MAX_HOLD      = 3'd3;
   localparam logic [IndexWidth-1:0] REG_SHORT_MAX     = 3'd4;
   localparam logic [IndexWidth-1:0] REG_LONG_MIN      = 3'd5;
   localparam logic [IndexWidth-1:0] REG_VERY_LONG_MIN = 3'd6;

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [DebWidth-1:0]   deb_type;
   typedef logic [KindWidth-1:0]  kind_type;

   typedef struct packed {
      logic      active_low;
      deb_type   debounce_ticks;
      count_type window_ticks;
      count_type max_hold_ticks;
      count_type short_max_ticks;
      count_type long_min_ticks;
      count_type very_long_min_ticks;
   } cfg_type;

   // Map a measured hold onto a press kind; the middle zone counts as long
   function automatic kind_type classify(count_type held, cfg_type cfg);
      kind_type kind;
      if (held >= cfg.very_long_min_ticks) begin
         kind = KIND_VERY_LONG;
      end else if (held >= cfg.long_min_ticks) begin
         kind = KIND_LONG;
      end else if (held <= cfg.short_max_ticks) begin
         kind = KIND_SHORT;
      end else begin
         kind = KIND_LONG;
      end
      return kind;
   endfunction

endpackage

@@ hw/rtl/bplc_if.sv @@
// Tick request channel
interface bplc_req_if;
   logic valid;
   logic ready;
   logic restart;
   logic pin_level;

   modport source (output valid, output restart, output pin_level, input ready);
   modport sink (input valid, input restart, input pin_level, output ready);
endinterface

// Result channel
interface bplc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bplc_pkg::KindWidth-1:0]     press_kind;
   logic [bplc_pkg::CountWidth-1:0]    held_ticks;

   modport source (output valid, output press_kind, output held_ticks, input ready);
   modport sink (input valid, input press_kind, input held_ticks, output ready);
endinterface

// Register write channel
interface bplc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [bplc_pkg::IndexWidth-1:0]    index;
   logic [bplc_pkg::DataWidth-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/bplc_core.sv @@
module bplc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                restart,
   input  logic                pin_level,
   input  bplc_pkg::cfg_type   cfg,
   output logic                emit,
   output bplc_pkg::kind_type  press_kind,
   output bplc_pkg::count_type held_ticks
);
   import bplc_pkg::*;

   localparam logic [1:0] PH_WAIT     = 2'd0;
   localparam logic [1:0] PH_DEBOUNCE = 2'd1;
   localparam logic [1:0] PH_HOLD     = 2'd2;
   localparam logic [1:0] PH_DONE     = 2'd3;

   localparam count_type CountMax = '1;
   localparam deb_type   DebMax   = '1;

   logic [1:0] phase_ff, phase_in;
   count_type  window_ff, window_in;
   deb_type    debounce_ff, debounce_in;
   count_type  hold_ff, hold_in;

   logic       active;
   logic [1:0] ph;
   count_type  wc;
   deb_type    dc;
   count_type  hc;
   count_type  wc_inc;
   deb_type    dc_inc;
   count_type  hc_inc;

   // Resolve polarity
   assign active = cfg.active_low ? ~pin_level : pin_level;

   // Apply restart before evaluating the tick
   assign ph = restart ? PH_WAIT : phase_ff;
   assign wc = restart ? '0 : window_ff;
   assign dc = restart ? '0 : debounce_ff;
   assign hc = restart ? '0 : hold_ff;

   // Saturating increments
   assign wc_inc = (wc == CountMax) ? wc : wc + count_type'(1);
   assign dc_inc = (dc == DebMax) ? dc : dc + deb_type'(1);
   assign hc_inc = (hc == CountMax) ? hc : hc + count_type'(1);

   // Evaluate one tick
   always_comb begin
      phase_in    = ph;
      window_in   = wc;
      debounce_in = dc;
      hold_in     = hc;
      emit        = 1'b0;
      press_kind  = KIND_NONE;
      held_ticks  = '0;
      case (ph)
         PH_WAIT: begin
            if (wc >= cfg.window_ticks) begin
               phase_in = PH_DONE;
               emit     = 1'b1;
            end else begin
               window_in = wc_inc;
               if (active) begin
                  if (cfg.debounce_ticks == '0) begin
                     hold_in  = '0;
                     phase_in = PH_HOLD;
                  end else begin
                     debounce_in = '0;
                     phase_in    = PH_DEBOUNCE;
                  end
               end
            end
         end
         PH_DEBOUNCE: begin
            window_in   = wc_inc;
            debounce_in = dc_inc;
            if (dc_inc >= cfg.debounce_ticks) begin
               if (active) begin
                  hold_in  = '0;
                  phase_in = PH_HOLD;
               end else begin
                  phase_in = PH_WAIT;
               end
            end
         end
         PH_HOLD: begin
            if (!active || hc >= cfg.max_hold_ticks) begin
               phase_in   = PH_DONE;
               emit       = 1'b1;
               press_kind = classify(hc, cfg);
               held_ticks = hc;
            end else begin
               hold_in = hc_inc;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   // Commit state on each processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         window_ff   <= '0;
         debounce_ff <= '0;
         hold_ff     <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         debounce_ff <= debounce_in;
         hold_ff     <= hold_in;
      end
   end

   // A reported result closes the detection
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      step_en && emit |=> phase_ff == PH_DONE)
      else $error("result reported without closing the detection");

   // A closed detection stays silent until restarted
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      step_en && !restart && phase_ff == PH_DONE |-> !emit)
      else $error("result from a closed detection");

   // A missed window carries no hold time
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      step_en && emit && press_kind == KIND_NONE |-> held_ticks == '0)
      else $error("none result with hold time");

   // Hold time never shrinks while holding
   a_hold_mono: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HOLD && !(step_en && restart) |=> hold_ff >= $past(hold_ff))
      else $error("hold count went backwards");

endmodule

@@ hw/rtl/button_press_length_classifier.sv @@
// Channel   Port  Direction  Payload
// ticks     req   in         restart, pin_level
// results   rsp   out        press_kind, held_ticks
// registers csr   in         index (3 bits), data (16 bits)
//
// One tick request is taken every clock cycle unless the result stalls.
// The tick register feeds the classifier logic, which writes the result register.
// Reset clears the detection state and loads the register defaults; no clearing pass.
// A stalled result holds the tick register, which in turn drops req.ready.
// Register writes are taken every cycle.
module button_press_length_classifier (
   input logic       clock,
   input logic       reset,
   bplc_req_if.sink  req,
   bplc_rsp_if.source rsp,
   bplc_csr_if.sink  csr
);
   import bplc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      tick_valid_ff, tick_valid_in;
   logic      restart_ff;
   logic      pin_level_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  kind_ff;
   count_type held_ff;

   logic      proceed;
   logic      emit;
   kind_type  kind;
   count_type held;

   // Advance the tick when the result slot is free or draining
   assign proceed       = tick_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready     = !tick_valid_ff || proceed;
   assign tick_valid_in = (req.valid && req.ready) || (tick_valid_ff && !proceed);
   assign rsp_valid_in  = (proceed && emit) || (rsp_valid_ff && !rsp.ready);
   assign csr.ready     = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_ACTIVE_LOW:    cfg_in.active_low          = csr.data[0];
            REG_DEBOUNCE:      cfg_in.debounce_ticks      = csr.data[DebWidth-1:0];
            REG_WINDOW:        cfg_in.window_ticks        = csr.data;
            REG_MAX_HOLD:      cfg_in.max_hold_ticks      = csr.data;
            REG_SHORT_MAX:     cfg_in.short_max_ticks     = csr.data;
            REG_LONG_MIN:      cfg_in.long_min_ticks      = csr.data;
            REG_VERY_LONG_MIN: cfg_in.very_long_min_ticks = csr.data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low          <= 1'b1;
         cfg_ff.debounce_ticks      <= deb_type'(30);
         cfg_ff.window_ticks        <= count_type'(3000);
         cfg_ff.max_hold_ticks      <= count_type'(10000);
         cfg_ff.short_max_ticks     <= count_type'(800);
         cfg_ff.long_min_ticks      <= count_type'(2000);
         cfg_ff.very_long_min_ticks <= count_type'(5000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Capture the tick request
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
      end
      if (req.valid && req.ready) begin
         restart_ff   <= req.restart;
         pin_level_ff <= req.pin_level;
      end
   end

   bplc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (proceed),
      .restart    (restart_ff),
      .pin_level  (pin_level_ff),
      .cfg        (cfg_ff),
      .emit       (emit),
      .press_kind (kind),
      .held_ticks (held)
   );

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (proceed && emit) begin
         kind_ff <= kind;
         held_ff <= held;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.press_kind = kind_ff;
   assign rsp.held_ticks = held_ff;

   // A waiting tick is never dropped while the result stalls
   a_tick_kept: assert property (@(posedge clock) disable iff (reset)
      tick_valid_ff && !proceed |=> tick_valid_ff)
      else $error("tick request lost under stall");

   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      proceed && emit |-> !rsp_valid_ff || rsp.ready)
      else $error("result overwritten before delivery");

endmodule
